// File: rtl/core/assert_macros.svh
// Assertion macros shared by the set table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, off while reset is held.
`define UVST_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Condition that must never be true.
`define UVST_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);

`endif

// File: rtl/core/uvst_pkg.sv
// Types, widths and codes for the unique value set table.
package uvst_pkg;

    localparam int DEPTH   = 64;
    localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int VAL_W   = 32;
    localparam int POS_W   = 6;
    localparam int KIND_W  = 2;
    localparam int STAT_W  = 2;
    localparam int CAP_W   = 7;
    localparam int COUNT_W = 7;
    localparam int LIM_W   = (CAP_W > CNT_W) ? CAP_W : CNT_W;
    localparam int PI_W    = (POS_W > IDX_W) ? POS_W : IDX_W;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    localparam logic [KIND_W-1:0] OP_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [KIND_W-1:0] OP_READ   = 2'd2;
    localparam logic [KIND_W-1:0] OP_CLEAR  = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_DUP   = 2'd2;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd3;

    // Query that walks the cell chain, one cell per clock.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [VAL_W-1:0]  value;
        logic [POS_W-1:0]  pos;
        logic              hit;
        logic [VAL_W-1:0]  elem;
    } tok_t;

    // Broadcast write of one entry.
    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic [VAL_W-1:0] data;
    } wr_t;

endpackage

// File: rtl/core/uvst_cell.sv
// One cell of the set chain: holds one entry and checks the passing query.
module uvst_cell (
    input  logic                    aclk,
    input  logic [uvst_pkg::IDX_W-1:0] cell_idx,
    input  logic [uvst_pkg::CNT_W-1:0] count,
    input  uvst_pkg::wr_t           wr,
    input  uvst_pkg::tok_t          tok_in,
    output uvst_pkg::tok_t          tok_out
);

    logic [uvst_pkg::VAL_W-1:0] entry_reg;
    uvst_pkg::tok_t             tok_reg;
    uvst_pkg::tok_t             tok_next;
    logic                       active;
    logic                       pos_match;

    // Only cells below the fill count hold live entries.
    assign active    = uvst_pkg::CNT_W'(cell_idx) < count;
    assign pos_match = uvst_pkg::PI_W'(tok_in.pos) == uvst_pkg::PI_W'(cell_idx);

    always_comb begin
        tok_next     = tok_in;
        tok_next.hit = tok_in.hit | (active && (entry_reg == tok_in.value));
        if (active && pos_match) begin
            tok_next.elem = entry_reg;
        end
    end

    always_ff @(posedge aclk) begin
        tok_reg <= tok_next;
        if (wr.en && (wr.idx == cell_idx)) begin
            entry_reg <= wr.data;
        end
    end

    assign tok_out = tok_reg;

endmodule

// File: rtl/core/uvst_chain.sv
// Row of set cells; the query enters at cell zero and leaves after the last.
module uvst_chain (
    input  logic                       aclk,
    input  logic [uvst_pkg::CNT_W-1:0] count,
    input  uvst_pkg::wr_t              wr,
    input  uvst_pkg::tok_t             tok_head,
    output uvst_pkg::tok_t             tok_tail
);

    uvst_pkg::tok_t toks [0:uvst_pkg::DEPTH];

    assign toks[0] = tok_head;

    for (genvar i = 0; i < uvst_pkg::DEPTH; i++) begin : g_cell
        uvst_cell u_cell (
            .aclk     (aclk),
            .cell_idx (uvst_pkg::IDX_W'(i)),
            .count    (count),
            .wr       (wr),
            .tok_in   (toks[i]),
            .tok_out  (toks[i+1])
        );
    end

    assign tok_tail = toks[uvst_pkg::DEPTH];

endmodule

// File: rtl/core/unique_value_set_table_unit.sv
// One operation is in flight at a time: a new beat is taken only after the last result is accepted.
// The accepted beat is registered at the chain head and walks the 64-cell chain one cell per clock;
// the result is then registered and held until the output is accepted.
// Reset: aresetn low at a clock edge empties the set and sets capacity to 64.
// Entry contents are not cleared; only entries below the fill count are ever used.
`include "assert_macros.svh"

module unique_value_set_table_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // value[31:0], position[37:32], zero fill
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // status[1:0], found[2], element[34:3], count[41:35], zero fill
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0]                       state_reg, state_next;
    logic [uvst_pkg::CNT_W-1:0]       step_reg, step_next;
    logic [uvst_pkg::CNT_W-1:0]       count_reg, count_next;
    logic [uvst_pkg::CAP_W-1:0]       cap_reg;
    uvst_pkg::tok_t                   tok_head_reg;
    uvst_pkg::tok_t                   tok_tail;
    uvst_pkg::wr_t                    wr;
    logic [47:0]                      res_reg, res_next;
    logic                             s_accept;
    logic                             finish;
    logic                             ins_ok;
    logic [uvst_pkg::LIM_W-1:0]       cap_ext, limit, count_ext, pos_ext;
    logic                             full;
    logic [uvst_pkg::STAT_W-1:0]      status;
    logic                             found;
    logic [uvst_pkg::VAL_W-1:0]       element;

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = (state_reg == ST_OUT);
    assign cfg_ready = 1'b1;
    assign m_tdata   = res_reg;
    assign s_accept  = s_tvalid && s_tready;
    assign finish    = (state_reg == ST_RUN) && (step_reg == uvst_pkg::CNT_W'(uvst_pkg::DEPTH));

    // The limit is the configured capacity, clipped to the number of cells.
    assign cap_ext   = uvst_pkg::LIM_W'(cap_reg);
    assign limit     = (cap_ext > uvst_pkg::LIM_W'(uvst_pkg::DEPTH)) ?
                       uvst_pkg::LIM_W'(uvst_pkg::DEPTH) : cap_ext;
    assign count_ext = uvst_pkg::LIM_W'(count_reg);
    assign pos_ext   = uvst_pkg::LIM_W'(tok_tail.pos);
    assign full      = (count_ext >= limit)
                       || (count_ext >= uvst_pkg::LIM_W'(uvst_pkg::DEPTH));

    always_comb begin
        status  = uvst_pkg::STAT_OK;
        found   = 1'b0;
        element = '0;
        ins_ok  = 1'b0;
        case (tok_tail.kind)
            uvst_pkg::OP_INSERT: begin
                found = tok_tail.hit;
                if (full) begin
                    status = uvst_pkg::STAT_FULL;
                end else if (tok_tail.hit) begin
                    status = uvst_pkg::STAT_DUP;
                end else begin
                    ins_ok = 1'b1;
                end
            end
            uvst_pkg::OP_LOOKUP: begin
                found = tok_tail.hit;
            end
            uvst_pkg::OP_READ: begin
                if (pos_ext >= count_ext) begin
                    status = uvst_pkg::STAT_RANGE;
                end else begin
                    element = tok_tail.elem;
                end
            end
            default: begin
            end
        endcase
    end

    assign wr.en   = finish && ins_ok;
    assign wr.idx  = count_reg[uvst_pkg::IDX_W-1:0];
    assign wr.data = tok_tail.value;

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        count_next = count_reg;
        res_next   = res_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_RUN;
                    step_next  = '0;
                end
            end
            ST_RUN: begin
                if (finish) begin
                    state_next = ST_OUT;
                    if (ins_ok) begin
                        count_next = count_reg + 1'b1;
                    end else if (tok_tail.kind == uvst_pkg::OP_CLEAR) begin
                        count_next = '0;
                    end
                    res_next = {6'b0, uvst_pkg::COUNT_W'(count_next), element, found, status};
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_OUT: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            count_reg <= '0;
            cap_reg   <= uvst_pkg::CAP_RESET;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            count_reg <= count_next;
            if (cfg_valid && cfg_ready) begin
                cap_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
        if (s_accept) begin
            tok_head_reg.kind  <= s_tuser;
            tok_head_reg.value <= s_tdata[31:0];
            tok_head_reg.pos   <= s_tdata[37:32];
            tok_head_reg.hit   <= 1'b0;
            tok_head_reg.elem  <= '0;
        end
    end

    uvst_chain u_chain (
        .aclk     (aclk),
        .count    (count_reg),
        .wr       (wr),
        .tok_head (tok_head_reg),
        .tok_tail (tok_tail)
    );

    `UVST_ASSERT(a_count_bound, aclk, aresetn, count_reg <= uvst_pkg::CNT_W'(uvst_pkg::DEPTH), "fill count exceeds cell count")
    `UVST_NEVER(a_one_in_flight, aclk, aresetn, s_tready && m_tvalid, "input taken while a result is pending")
    `UVST_ASSERT(a_write_in_limit, aclk, aresetn, wr.en |-> (count_ext < limit), "entry written beyond the limit")
    `UVST_ASSERT(a_insert_grows, aclk, aresetn, wr.en |=> (count_reg == $past(count_reg) + 1'b1), "insert did not grow the count")

endmodule

// File: tb/sv/unique_value_set_table_unit_tb.sv
// Self-checking testbench for the unique value set table: directed table, then random phases.
`timescale 1ns / 1ps

module unique_value_set_table_unit_tb;

    typedef struct packed {
        logic [uvst_pkg::STAT_W-1:0]  status;
        logic                         found;
        logic [uvst_pkg::VAL_W-1:0]   element;
        logic [uvst_pkg::COUNT_W-1:0] count;
    } set_result_t;

    typedef enum logic {ROW_OP, ROW_CAP} row_kind_t;

    typedef struct packed {
        row_kind_t                   rk;
        logic [uvst_pkg::KIND_W-1:0] kind;
        logic [uvst_pkg::VAL_W-1:0]  value;
        logic [uvst_pkg::POS_W-1:0]  pos;
        logic [uvst_pkg::CAP_W-1:0]  cap;
        logic                        typed;
        set_result_t                 want;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;   // value[31:0], position[37:32], zero fill
    logic [1:0]  s_tuser = '0;   // kind[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;        // status[1:0], found[2], element[34:3], count[41:35], zero fill
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [6:0]  cfg_data = '0;

    // Shadow copy of the set, kept in step with accepted beats.
    logic [uvst_pkg::VAL_W-1:0]   set_vals [uvst_pkg::DEPTH];
    logic [uvst_pkg::COUNT_W-1:0] set_fill;
    logic [uvst_pkg::CAP_W-1:0]   set_cap;
    set_result_t                  pending_results [$];

    logic        typed_pending = 1'b0;
    set_result_t typed_want = '0;
    int          tx_idle_pct = 0;
    int          rx_stall_pct = 0;
    int          err_count = 0;
    int          n_ops = 0;
    int          n_status [4] = '{0, 0, 0, 0};
    int          peak_fill = 0;
    dir_row_t    dir_rows [$];

    unique_value_set_table_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    function automatic set_result_t apply_set_op(input logic [uvst_pkg::KIND_W-1:0] k,
                                                 input logic [uvst_pkg::VAL_W-1:0] v,
                                                 input logic [uvst_pkg::POS_W-1:0] p);
        set_result_t r;
        logic        hit;
        int          lim;
        r = '0;
        hit = 1'b0;
        for (int i = 0; i < set_fill; i++) begin
            if (set_vals[i] == v) hit = 1'b1;
        end
        lim = (set_cap > uvst_pkg::DEPTH) ? uvst_pkg::DEPTH : set_cap;
        case (k)
            uvst_pkg::OP_INSERT: begin
                r.found = hit;
                if (set_fill >= lim) begin
                    r.status = uvst_pkg::STAT_FULL;
                end else if (hit) begin
                    r.status = uvst_pkg::STAT_DUP;
                end else if (set_fill < uvst_pkg::DEPTH) begin
                    set_vals[set_fill] = v;
                    set_fill = set_fill + 1'b1;
                end else begin
                    r.status = uvst_pkg::STAT_FULL;
                end
            end
            uvst_pkg::OP_LOOKUP: r.found = hit;
            uvst_pkg::OP_READ: begin
                if (p >= set_fill) r.status = uvst_pkg::STAT_RANGE;
                else r.element = set_vals[p];
            end
            default: set_fill = '0;
        endcase
        r.count = set_fill;
        return r;
    endfunction

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // Input beats are predicted before output beats are checked within the same edge.
    always @(posedge aclk) begin : set_monitor
        set_result_t want;
        set_result_t got;
        if (!aresetn) begin
            set_fill = '0;
            set_cap = uvst_pkg::CAP_RESET;
        end else begin
            if (cfg_valid && cfg_ready) set_cap = cfg_data;
            if (s_tvalid && s_tready) begin
                want = apply_set_op(s_tuser, s_tdata[31:0], s_tdata[37:32]);
                if (typed_pending) want = typed_want;
                pending_results.push_back(want);
                n_ops++;
                if (set_fill > peak_fill) peak_fill = set_fill;
            end
            if (m_tvalid && m_tready) begin
                got.status  = m_tdata[1:0];
                got.found   = m_tdata[2];
                got.element = m_tdata[34:3];
                got.count   = m_tdata[41:35];
                if (pending_results.size() == 0) begin
                    $error("result beat with nothing outstanding: %h", m_tdata);
                    err_count++;
                end else begin
                    want = pending_results.pop_front();
                    n_status[got.status]++;
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        err_count++;
                    end
                    if (got.found !== want.found) begin
                        $error("found: expected %0d, got %0d", want.found, got.found);
                        err_count++;
                    end
                    if (got.element !== want.element) begin
                        $error("element: expected %0d, got %0d",
                               $signed(want.element), $signed(got.element));
                        err_count++;
                    end
                    if (got.count !== want.count) begin
                        $error("count: expected %0d, got %0d", want.count, got.count);
                        err_count++;
                    end
                end
            end
        end
    end

    function automatic void op_row(input logic [uvst_pkg::KIND_W-1:0] k,
                                   input logic [uvst_pkg::VAL_W-1:0] v,
                                   input logic [uvst_pkg::POS_W-1:0] p);
        dir_row_t row;
        row = '0;
        row.rk = ROW_OP;
        row.kind = k;
        row.value = v;
        row.pos = p;
        dir_rows.push_back(row);
    endfunction

    function automatic void typed_row(input logic [uvst_pkg::KIND_W-1:0] k,
                                      input logic [uvst_pkg::VAL_W-1:0] v,
                                      input logic [uvst_pkg::POS_W-1:0] p,
                                      input logic [uvst_pkg::STAT_W-1:0] st,
                                      input logic fnd, input logic [uvst_pkg::VAL_W-1:0] el,
                                      input logic [uvst_pkg::COUNT_W-1:0] cnt);
        dir_row_t row;
        row = '0;
        row.rk = ROW_OP;
        row.kind = k;
        row.value = v;
        row.pos = p;
        row.typed = 1'b1;
        row.want.status = st;
        row.want.found = fnd;
        row.want.element = el;
        row.want.count = cnt;
        dir_rows.push_back(row);
    endfunction

    function automatic void cap_row(input logic [uvst_pkg::CAP_W-1:0] c);
        dir_row_t row;
        row = '0;
        row.rk = ROW_CAP;
        row.cap = c;
        dir_rows.push_back(row);
    endfunction

    // Entered and left at a falling edge; valid stays high between back-to-back beats.
    task automatic send_op(input logic [uvst_pkg::KIND_W-1:0] k,
                           input logic [uvst_pkg::VAL_W-1:0] v,
                           input logic [uvst_pkg::POS_W-1:0] p, input logic typed,
                           input set_result_t want);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, p, v};
        s_tuser <= k;
        typed_pending = typed;
        typed_want = want;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic wait_set_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
    endtask

    task automatic write_capacity(input logic [uvst_pkg::CAP_W-1:0] c);
        wait_set_idle();
        cfg_valid <= 1'b1;
        cfg_data <= c;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_set_op(input int clear_pct);
        logic [uvst_pkg::KIND_W-1:0] k;
        logic [uvst_pkg::VAL_W-1:0]  v;
        logic [uvst_pkg::POS_W-1:0]  p;
        int                          r;
        r = $urandom_range(0, 99);
        if (r < clear_pct) k = uvst_pkg::OP_CLEAR;
        else if (r < 50) k = uvst_pkg::OP_INSERT;
        else if (r < 75) k = uvst_pkg::OP_LOOKUP;
        else k = uvst_pkg::OP_READ;
        // Mostly values already held or nearby, so duplicates and hits are common.
        r = $urandom_range(0, 99);
        if (r < 40 && set_fill != 0) begin
            v = set_vals[$urandom_range(0, set_fill - 1)];
        end else if (r < 60) begin
            v = $urandom_range(0, 15);
        end else if (r < 75) begin
            case ($urandom_range(0, 3))
                0: v = 32'h8000_0000;
                1: v = 32'h7FFF_FFFF;
                2: v = 32'h0000_0000;
                default: v = 32'hFFFF_FFFF;
            endcase
        end else begin
            v = $urandom;
        end
        if ($urandom_range(0, 99) < 70) begin
            p = uvst_pkg::POS_W'($urandom_range(0, (set_fill > 63) ? 63 : set_fill));
        end else begin
            p = uvst_pkg::POS_W'($urandom_range(0, 63));
        end
        send_op(k, v, p, 1'b0, '0);
    endtask

    initial begin : stimulus
        int phase_caps [8];
        int clear_pcts [8];
        int cap;
        phase_caps = '{64, 127, 1, 20, 0, 64, 0, 33};
        clear_pcts = '{2, 0, 3, 2, 2, 1, 3, 2};

        typed_row(uvst_pkg::OP_READ,   32'h0,         6'd0,  uvst_pkg::STAT_RANGE, 1'b0,
                  32'h0, 7'd0);
        typed_row(uvst_pkg::OP_LOOKUP, 32'h0,         6'd0,  uvst_pkg::STAT_OK,    1'b0,
                  32'h0, 7'd0);
        typed_row(uvst_pkg::OP_INSERT, 32'h8000_0000, 6'd0,  uvst_pkg::STAT_OK,    1'b0,
                  32'h0, 7'd1);
        typed_row(uvst_pkg::OP_INSERT, 32'h7FFF_FFFF, 6'd63, uvst_pkg::STAT_OK,    1'b0,
                  32'h0, 7'd2);
        typed_row(uvst_pkg::OP_INSERT, 32'h8000_0000, 6'd0,  uvst_pkg::STAT_DUP,   1'b1,
                  32'h0, 7'd2);
        typed_row(uvst_pkg::OP_LOOKUP, 32'h7FFF_FFFF, 6'd0,  uvst_pkg::STAT_OK,    1'b1,
                  32'h0, 7'd2);
        typed_row(uvst_pkg::OP_READ,   32'hFFFF_FFFF, 6'd1,  uvst_pkg::STAT_OK,    1'b0,
                  32'h7FFF_FFFF, 7'd2);
        typed_row(uvst_pkg::OP_READ,   32'h0,         6'd63, uvst_pkg::STAT_RANGE, 1'b0,
                  32'h0, 7'd2);
        op_row(uvst_pkg::OP_INSERT, 32'hFFFF_FFFF, 6'd0);
        op_row(uvst_pkg::OP_INSERT, 32'h0, 6'd0);
        op_row(uvst_pkg::OP_LOOKUP, 32'h1, 6'd0);
        op_row(uvst_pkg::OP_READ, 32'h0, 6'd3);
        typed_row(uvst_pkg::OP_CLEAR,  32'h1234_5678, 6'd5,  uvst_pkg::STAT_OK,    1'b0,
                  32'h0, 7'd0);
        // Entries left behind by the clear must not match.
        typed_row(uvst_pkg::OP_LOOKUP, 32'h7FFF_FFFF, 6'd0,  uvst_pkg::STAT_OK,    1'b0,
                  32'h0, 7'd0);
        typed_row(uvst_pkg::OP_READ,   32'h0,         6'd0,  uvst_pkg::STAT_RANGE, 1'b0,
                  32'h0, 7'd0);
        cap_row(7'd1);
        typed_row(uvst_pkg::OP_INSERT, 32'd5, 6'd0, uvst_pkg::STAT_OK,   1'b0, 32'h0, 7'd1);
        typed_row(uvst_pkg::OP_INSERT, 32'd6, 6'd0, uvst_pkg::STAT_FULL, 1'b0, 32'h0, 7'd1);
        // Full wins over duplicate, but found still reports the hit.
        typed_row(uvst_pkg::OP_INSERT, 32'd5, 6'd0, uvst_pkg::STAT_FULL, 1'b1, 32'h0, 7'd1);
        cap_row(7'd0);
        typed_row(uvst_pkg::OP_LOOKUP, 32'd5, 6'd0, uvst_pkg::STAT_OK,   1'b1, 32'h0, 7'd1);
        typed_row(uvst_pkg::OP_INSERT, 32'd7, 6'd0, uvst_pkg::STAT_FULL, 1'b0, 32'h0, 7'd1);
        cap_row(7'd127);
        op_row(uvst_pkg::OP_INSERT, 32'd7, 6'd0);
        op_row(uvst_pkg::OP_CLEAR, 32'h0, 6'd0);

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].rk == ROW_CAP) write_capacity(dir_rows[i].cap);
            else send_op(dir_rows[i].kind, dir_rows[i].value, dir_rows[i].pos,
                         dir_rows[i].typed, dir_rows[i].want);
        end

        for (int ph = 0; ph < 8; ph++) begin
            cap = (ph == 6) ? $urandom_range(0, 127) : phase_caps[ph];
            write_capacity(uvst_pkg::CAP_W'(cap));
            case (ph % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 82; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 82; end
                default: begin tx_idle_pct = 21; rx_stall_pct = 21; end
            endcase
            for (int n = 0; n < 190; n++) begin
                if ($urandom_range(0, 79) == 0) wait_set_idle();
                random_set_op(clear_pcts[ph]);
            end
        end

        wait_set_idle();
        repeat (80) @(negedge aclk);
        $display("Covered %0d operations over 8 capacity settings plus directed cases, peak fill %0d.",
                 n_ops, peak_fill);
        $display("Results seen: ok %0d, full %0d, duplicate %0d, out of range %0d.",
                 n_status[0], n_status[1], n_status[2], n_status[3]);
        if (err_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin : watchdog
        #4_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
